// ===== hdl/polynomial_multiply_mod_q_defines.svh =====
// ----------------------------------------------------------------------------
// Polynomial multiplier modulo q: assertion macros
// Shared concurrent assertion forms for the checker of this block.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_MULTIPLY_MOD_Q_DEFINES_SVH
`define POLYNOMIAL_MULTIPLY_MOD_Q_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PMQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PMQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pmq_pkg.sv =====
// ----------------------------------------------------------------------------
// Polynomial multiplier modulo q: package
// Field widths, stream packing positions, action codes and defaults.
// ----------------------------------------------------------------------------
package pmq_pkg;

  // Default sizing of the term stores.
  localparam int MAX_TERMS_DEF  = 32;
  localparam int COEFF_BITS_DEF = 16;

  // Field widths of the stream items and the modulus register.
  localparam int ACTION_W  = 2;
  localparam int IDX_W     = 5;
  localparam int VAL_W     = 16;
  localparam int CNT_W     = 6;
  localparam int OUT_IDX_W = 6;
  localparam int MOD_W     = 16;

  // Packing of the input tdata word, lowest field first.
  localparam int IDX_LSB   = 0;
  localparam int VAL_LSB   = IDX_LSB + IDX_W;
  localparam int FCNT_LSB  = VAL_LSB + VAL_W;
  localparam int SCNT_LSB  = FCNT_LSB + CNT_W;
  localparam int S_TDATA_W = 40;

  // Packing of the output tdata word: index, then value, then padding.
  localparam int M_TDATA_W = 24;

  // Reset value of the modulus register.
  localparam logic [MOD_W-1:0] MOD_RESET = 16'd2048;

  // Action codes carried in the input tuser field.
  localparam logic [ACTION_W-1:0] ACT_LOAD_FIRST  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_SECOND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MULTIPLY    = 2'd2;

endpackage

// ===== hdl/pmq_ram.sv =====
// ----------------------------------------------------------------------------
// Polynomial multiplier modulo q: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pmq_ram #(
  parameter int AddrW = 5,
  parameter int DataW = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [2**AddrW];
  logic [DataW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pmq_mod_reduce.sv =====
// ----------------------------------------------------------------------------
// Polynomial multiplier modulo q: bit-serial modular reduction
// Reduces an exact coefficient sum modulo q, one sum bit per cycle.
// ----------------------------------------------------------------------------
module pmq_mod_reduce #(
  parameter int SumW = 37
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [SumW-1:0]           value_i,
  input  logic [pmq_pkg::MOD_W:0]   modulus_i,
  output logic                      done_o,
  output logic [pmq_pkg::MOD_W-1:0] rem_o
);
  import pmq_pkg::*;

  localparam int CntW = $clog2(SumW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [SumW-1:0] sh_q;
  logic [MOD_W:0]  rem_q;
  logic [MOD_W:0]  trial;

  // Shift in the next sum bit; the partial remainder stays below q, so one
  // compare and subtract keeps it reduced.
  assign trial = {rem_q[MOD_W-1:0], sh_q[SumW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(SumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= value_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= sh_q << 1;
      rem_q <= (trial >= modulus_i) ? trial - modulus_i : trial;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[MOD_W-1:0];

endmodule

// ===== hdl/polynomial_multiply_mod_q.sv =====
// Operation: the time of a multiply of na by nb terms is set mostly by the
// bit-serial reduction of each coefficient sum, and each result is emitted
// through a read state and then a load state. One item is in work at a time.
// Reset clears control state and sets the modulus to 2048; the term stores
// are not cleared and hold unknown data until loaded.
// ----------------------------------------------------------------------------
// Polynomial multiplier modulo q: top level
// Schoolbook linear product of two stored operand polynomials, reduced mod q.
// ----------------------------------------------------------------------------
module polynomial_multiply_mod_q #(
  parameter int MAX_TERMS  = pmq_pkg::MAX_TERMS_DEF,
  parameter int COEFF_BITS = pmq_pkg::COEFF_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: term_index, term_value, first_count, second_count.
  input  logic [pmq_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // Fields from bit 0: action.
  input  logic [pmq_pkg::ACTION_W-1:0]  s_axis_tuser,
  // Result items.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: out_index, out_value.
  output logic [pmq_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // is_last.
  output logic                          m_axis_tlast,
  // Fields from bit 0: is_empty.
  output logic                          m_axis_tuser,
  // Modulus register write.
  input  logic                          cfg_we_i,
  input  logic [pmq_pkg::MOD_W-1:0]     cfg_wdata_i
);
  import pmq_pkg::*;

  localparam int TW     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW     = $clog2(MAX_TERMS + 1);
  localparam int KW     = $clog2(2 * MAX_TERMS);
  localparam int PROD_W = 2 * COEFF_BITS;
  localparam int SUM_W  = PROD_W + $clog2(MAX_TERMS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_COEF,
    S_MAC,
    S_DRAIN,
    S_RED,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMPTY
  } state_e;

  state_e              state_q;
  logic [MOD_W-1:0]    modulus_q;
  logic [CW-1:0]       na_q, nb_q;
  logic [KW-1:0]       k_q, kend_q, top_q, n_q;
  logic [TW-1:0]       i_q, j_q, ihi_q;
  logic                found_q;
  logic                v1_q, v2_q;
  logic [PROD_W-1:0]   prod_q;
  logic [SUM_W-1:0]    acc_q;
  logic                m_valid_q;
  logic [OUT_IDX_W-1:0] out_idx_q;
  logic [MOD_W-1:0]    out_val_q;
  logic                out_last_q;
  logic                out_empty_q;

  // Input field unpacking.
  logic [ACTION_W-1:0] action;
  logic [IDX_W-1:0]    term_index;
  logic [VAL_W-1:0]    term_value;
  logic [CNT_W-1:0]    first_count, second_count;
  logic                in_accept;
  logic                in_range;

  assign action       = s_axis_tuser;
  assign term_index   = s_axis_tdata[IDX_LSB +: IDX_W];
  assign term_value   = s_axis_tdata[VAL_LSB +: VAL_W];
  assign first_count  = s_axis_tdata[FCNT_LSB +: CNT_W];
  assign second_count = s_axis_tdata[SCNT_LSB +: CNT_W];
  assign in_accept    = s_axis_tvalid && s_axis_tready;
  assign in_range     = 32'(term_index) < MAX_TERMS;

  // Counts saturate at the store depth.
  logic [CW-1:0] na_d, nb_d;
  logic [KW-1:0] kend_d;

  assign na_d   = (32'(first_count) > MAX_TERMS) ? CW'(MAX_TERMS) : CW'(first_count);
  assign nb_d   = (32'(second_count) > MAX_TERMS) ? CW'(MAX_TERMS) : CW'(second_count);
  assign kend_d = KW'(na_d) + KW'(nb_d) - KW'(2);

  // Range of first-operand indexes that contribute to coefficient k.
  logic [KW-1:0] na_k, nb_k, ilo, ihi;

  assign na_k = KW'(na_q);
  assign nb_k = KW'(nb_q);
  assign ilo  = (k_q >= nb_k) ? k_q - nb_k + KW'(1) : '0;
  assign ihi  = (k_q < na_k - KW'(1)) ? k_q : na_k - KW'(1);

  // Operand term stores.
  logic [COEFF_BITS-1:0] a_rdata, b_rdata;
  logic                  a_we, b_we;

  assign a_we = in_accept && (action == ACT_LOAD_FIRST) && in_range;
  assign b_we = in_accept && (action == ACT_LOAD_SECOND) && in_range;

  pmq_ram #(
    .AddrW (TW),
    .DataW (COEFF_BITS)
  ) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (TW'(term_index)),
    .wdata_i (COEFF_BITS'(term_value)),
    .raddr_i (i_q),
    .rdata_o (a_rdata)
  );

  pmq_ram #(
    .AddrW (TW),
    .DataW (COEFF_BITS)
  ) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (TW'(term_index)),
    .wdata_i (COEFF_BITS'(term_value)),
    .raddr_i (j_q),
    .rdata_o (b_rdata)
  );

  // Modular reduction of each finished coefficient sum.
  logic [MOD_W:0]   mod_eff;
  logic             red_start;
  logic             red_done;
  logic [MOD_W-1:0] red_rem;

  assign mod_eff   = (modulus_q == '0) ? {1'b1, {MOD_W{1'b0}}} : {1'b0, modulus_q};
  assign red_start = (state_q == S_DRAIN) && !v1_q && !v2_q;

  pmq_mod_reduce #(
    .SumW (SUM_W)
  ) u_reduce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (red_start),
    .value_i   (acc_q),
    .modulus_i (mod_eff),
    .done_o    (red_done),
    .rem_o     (red_rem)
  );

  // Product coefficient store, read back in order for emission.
  logic             coef_we;
  logic [MOD_W-1:0] coef_rdata;

  assign coef_we = (state_q == S_RED) && red_done;

  pmq_ram #(
    .AddrW (KW),
    .DataW (MOD_W)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (k_q),
    .wdata_i (red_rem),
    .raddr_i (n_q),
    .rdata_o (coef_rdata)
  );

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  // Sequencer: modulus register, coefficient loop, term-pair walk, emission and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      modulus_q   <= MOD_RESET;
      na_q        <= '0;
      nb_q        <= '0;
      k_q         <= '0;
      kend_q      <= '0;
      top_q       <= '0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      ihi_q       <= '0;
      found_q     <= 1'b0;
      m_valid_q   <= 1'b0;
      out_idx_q   <= '0;
      out_val_q   <= '0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        modulus_q <= cfg_wdata_i;
      end
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept && (action == ACT_MULTIPLY)) begin
            na_q    <= na_d;
            nb_q    <= nb_d;
            kend_q  <= kend_d;
            k_q     <= '0;
            n_q     <= '0;
            found_q <= 1'b0;
            state_q <= ((na_d == '0) || (nb_d == '0)) ? S_EMPTY : S_COEF;
          end
        end
        S_COEF: begin
          i_q     <= TW'(ilo);
          j_q     <= TW'(k_q - ilo);
          ihi_q   <= TW'(ihi);
          state_q <= S_MAC;
        end
        S_MAC: begin
          if (i_q == ihi_q) begin
            state_q <= S_DRAIN;
          end else begin
            i_q <= i_q + TW'(1);
            j_q <= j_q - TW'(1);
          end
        end
        S_DRAIN: begin
          if (!v1_q && !v2_q) begin
            state_q <= S_RED;
          end
        end
        S_RED: begin
          if (red_done) begin
            if (red_rem != '0) begin
              top_q   <= k_q;
              found_q <= 1'b1;
            end
            if (k_q == kend_q) begin
              state_q <= (found_q || (red_rem != '0)) ? S_EMIT_RD : S_EMPTY;
            end else begin
              k_q     <= k_q + KW'(1);
              state_q <= S_COEF;
            end
          end
        end
        S_EMIT_RD: begin
          if (out_free) begin
            state_q <= S_EMIT_LD;
          end
        end
        S_EMIT_LD: begin
          m_valid_q   <= 1'b1;
          out_idx_q   <= OUT_IDX_W'(n_q);
          out_val_q   <= coef_rdata;
          out_last_q  <= (n_q == top_q);
          out_empty_q <= 1'b0;
          if (n_q == top_q) begin
            state_q <= S_IDLE;
          end else begin
            n_q     <= n_q + KW'(1);
            state_q <= S_EMIT_RD;
          end
        end
        S_EMPTY: begin
          // Wait for the output register to drain, then load the empty item.
          if (!m_valid_q) begin
            m_valid_q   <= 1'b1;
            out_idx_q   <= '0;
            out_val_q   <= '0;
            out_last_q  <= 1'b1;
            out_empty_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Valid flags of the read and multiply stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= (state_q == S_MAC);
      v2_q <= v1_q;
    end
  end

  // Multiply-accumulate of the exact coefficient sum.
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= PROD_W'(a_rdata) * PROD_W'(b_rdata);
    end
    if (state_q == S_COEF) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + SUM_W'(prod_q);
    end
  end

  // Port outputs.
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - OUT_IDX_W - MOD_W){1'b0}}, out_val_q, out_idx_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_empty_q;

endmodule

// ===== hdl/pmq_checker.sv =====
// ----------------------------------------------------------------------------
// Polynomial multiplier modulo q: port checker
// Watches the top-level ports over time; bound to every top-level instance.
// ----------------------------------------------------------------------------
`include "polynomial_multiply_mod_q_defines.svh"

module pmq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [pmq_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic [pmq_pkg::ACTION_W-1:0]  s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pmq_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic                          m_axis_tuser,
  input logic                          cfg_we_i,
  input logic [pmq_pkg::MOD_W-1:0]     cfg_wdata_i
);
  import pmq_pkg::*;

  // A stalled result item keeps its contents.
  `PMQ_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "result item changed while stalled")

  // The empty product is a single item at power zero with value zero.
  `PMQ_ASSERT_IMP(a_empty_form, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0), "empty result is malformed")

  // Loads and unused actions keep the block in idle, so it stays ready.
  `PMQ_ASSERT_NXT(a_load_ready, s_axis_tvalid && s_axis_tready && (s_axis_tuser != ACT_MULTIPLY), s_axis_tready, "block busy after a load item")

  // A multiply occupies the block for at least the following cycle.
  `PMQ_ASSERT_NXT(a_mult_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_MULTIPLY), !s_axis_tready, "block ready right after a multiply item")

endmodule

bind polynomial_multiply_mod_q pmq_checker u_pmq_checker (.*);
